>>> src/spi_mp_pkg.sv
// ----------------------------------------------------------------------------
// spi_mp_pkg
// Shared types, codes and constants of the SPI master port.
// ----------------------------------------------------------------------------
package spi_mp_pkg;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned PRESC_W  = 7;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 2;
	localparam int unsigned BITS_PER_XFER = 8;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_WRITE  = 2'd1,
		MODE_STATUS = 2'd2,
		MODE_READ   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PORT_ENABLE = 3'd0,
		REG_LSB_FIRST   = 3'd1,
		REG_CLOCK_POL   = 3'd2,
		REG_CLOCK_PHASE = 3'd3,
		REG_RATE_SELECT = 3'd4,
		REG_DOUBLE_SPD  = 3'd5,
		REG_IRQ_ENABLE  = 3'd6
	} reg_idx_t;

	localparam int unsigned STATUS_DONE_BIT = 7;
	localparam int unsigned STATUS_COLL_BIT = 6;
	localparam int unsigned STATUS_DSPD_BIT = 0;

	typedef struct packed {
		logic       port_enable;
		logic       lsb_first;
		logic       clock_polarity;
		logic       clock_phase;
		logic [1:0] rate_select;
		logic       double_speed;
		logic       interrupt_enable;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [DATA_W-1:0] write_data;
		logic              miso_in;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              sclk_out;
		logic              mosi_out;
		logic              busy_res;
		logic              irq;
	} result_t;

	// half period of the serial clock in system ticks
	function automatic logic [PRESC_W-1:0] half_period(input logic [1:0] rate,
			input logic dbl);
		logic [PRESC_W-1:0] base;
		unique case (rate)
			2'd0: base = 7'd2;
			2'd1: base = 7'd8;
			2'd2: base = 7'd32;
			default: base = 7'd64;
		endcase
		return dbl ? (base >> 1) : base;
	endfunction

	function automatic logic out_bit(input logic [DATA_W-1:0] sr, input logic lsb);
		return lsb ? sr[0] : sr[DATA_W-1];
	endfunction

	function automatic logic [DATA_W-1:0] shift_in(input logic [DATA_W-1:0] sr,
			input logic lsb, input logic b);
		return lsb ? {b, sr[DATA_W-1:1]} : {sr[DATA_W-2:0], b};
	endfunction

endpackage

>>> src/spi_mp_if.sv
// ----------------------------------------------------------------------------
// spi_mp_if
// Valid/ready channels of the SPI master port: items, results, configuration.
// ----------------------------------------------------------------------------
interface spi_mp_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] write_data;
	logic       miso_in;

	modport source (output valid, output mode, output write_data, output miso_in,
		input ready);
	modport sink (input valid, input mode, input write_data, input miso_in,
		output ready);
endinterface

interface spi_mp_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       sclk_out;
	logic       mosi_out;
	logic       busy_res;
	logic       irq;

	modport source (output valid, output read_data, output sclk_out, output mosi_out,
		output busy_res, output irq, input ready);
	modport sink (input valid, input read_data, input sclk_out, input mosi_out,
		input busy_res, input irq, output ready);
endinterface

interface spi_mp_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] reg_index;
	logic [1:0] wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> src/spi_mp_cfg.sv
// ----------------------------------------------------------------------------
// spi_mp_cfg
// Configuration register file; flags a stop when the port is disabled.
// ----------------------------------------------------------------------------
module spi_mp_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	spi_mp_cfg_if.sink           cfg,
	output spi_mp_pkg::cfg_t     cfg_regs,
	output logic                 stop
);

	spi_mp_pkg::cfg_t cfg_q;
	logic             wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;
	assign cfg_regs  = cfg_q;
	assign stop      = wr && (cfg.reg_index == spi_mp_pkg::REG_PORT_ENABLE) && !cfg.wr_data[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (cfg.reg_index)
				spi_mp_pkg::REG_PORT_ENABLE: cfg_q.port_enable      <= cfg.wr_data[0];
				spi_mp_pkg::REG_LSB_FIRST:   cfg_q.lsb_first        <= cfg.wr_data[0];
				spi_mp_pkg::REG_CLOCK_POL:   cfg_q.clock_polarity   <= cfg.wr_data[0];
				spi_mp_pkg::REG_CLOCK_PHASE: cfg_q.clock_phase      <= cfg.wr_data[0];
				spi_mp_pkg::REG_RATE_SELECT: cfg_q.rate_select      <= cfg.wr_data;
				spi_mp_pkg::REG_DOUBLE_SPD:  cfg_q.double_speed     <= cfg.wr_data[0];
				spi_mp_pkg::REG_IRQ_ENABLE:  cfg_q.interrupt_enable <= cfg.wr_data[0];
				default: ;
			endcase
		end
	end

endmodule

>>> src/spi_mp_engine.sv
// ----------------------------------------------------------------------------
// spi_mp_engine
// Exchange state and the single-pass update for one system tick.
// ----------------------------------------------------------------------------
module spi_mp_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spi_mp_pkg::cfg_t     cfg_regs,
	input  logic                 stop,
	input  logic                 step,
	input  spi_mp_pkg::item_t    item,
	output spi_mp_pkg::result_t  res
);

	logic [spi_mp_pkg::DATA_W-1:0]  shift_q, rx_q, sr_d, rx_d, rd_d;
	logic [spi_mp_pkg::COUNT_W-1:0] bit_count_q, bc_d;
	logic [spi_mp_pkg::PRESC_W-1:0] presc_q, pc_d, pc_inc, half;
	logic half_q, active_q, done_q, coll_q, armed_q, held_q;
	logic hp_d, act_d, done_d, coll_d, armed_d, held_d, sclk_event;

	always_comb begin
		sr_d    = shift_q;
		bc_d    = bit_count_q;
		pc_d    = presc_q;
		hp_d    = half_q;
		act_d   = active_q;
		held_d  = held_q;
		done_d  = done_q;
		coll_d  = coll_q;
		armed_d = armed_q;
		rx_d    = rx_q;
		rd_d    = '0;

		if (!cfg_regs.port_enable) begin
			act_d = 1'b0;
			bc_d  = '0;
			pc_d  = '0;
			hp_d  = 1'b0;
		end

		half       = spi_mp_pkg::half_period(cfg_regs.rate_select, cfg_regs.double_speed);
		pc_inc     = pc_d + 1'b1;
		sclk_event = act_d && (pc_inc >= half);

		if (act_d) begin
			if (!sclk_event) begin
				pc_d = pc_inc;
			end else begin
				pc_d = '0;
				if (!hp_d) begin
					hp_d   = 1'b1;
					held_d = cfg_regs.clock_phase ?
						spi_mp_pkg::out_bit(sr_d, cfg_regs.lsb_first) : item.miso_in;
				end else begin
					hp_d = 1'b0;
					sr_d = spi_mp_pkg::shift_in(sr_d, cfg_regs.lsb_first,
						cfg_regs.clock_phase ? item.miso_in : held_d);
					bc_d = bc_d + 1'b1;
					if (bc_d[spi_mp_pkg::COUNT_W-1]) begin
						act_d  = 1'b0;
						bc_d   = '0;
						pc_d   = '0;
						rx_d   = sr_d;
						done_d = 1'b1;
					end
				end
			end
		end

		unique case (spi_mp_pkg::mode_t'(item.mode))
			spi_mp_pkg::MODE_TICK: ;
			spi_mp_pkg::MODE_WRITE: begin
				if (cfg_regs.port_enable) begin
					if (act_d) begin
						coll_d = 1'b1;
					end else begin
						sr_d  = item.write_data;
						act_d = 1'b1;
						bc_d  = '0;
						pc_d  = '0;
						hp_d  = 1'b0;
					end
				end
			end
			spi_mp_pkg::MODE_STATUS: begin
				rd_d[spi_mp_pkg::STATUS_DONE_BIT] = done_d;
				rd_d[spi_mp_pkg::STATUS_COLL_BIT] = coll_d;
				rd_d[spi_mp_pkg::STATUS_DSPD_BIT] = cfg_regs.double_speed;
				if (done_d || coll_d) begin
					armed_d = 1'b1;
				end
			end
			spi_mp_pkg::MODE_READ: begin
				rd_d = rx_d;
				if (armed_d) begin
					done_d  = 1'b0;
					coll_d  = 1'b0;
					armed_d = 1'b0;
				end
			end
			default: ;
		endcase

		res.read_data = rd_d;
		res.sclk_out  = cfg_regs.clock_polarity ^ hp_d;
		res.mosi_out  = cfg_regs.clock_phase ? held_d :
			spi_mp_pkg::out_bit(sr_d, cfg_regs.lsb_first);
		res.busy_res  = act_d;
		res.irq       = done_d & cfg_regs.interrupt_enable;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q     <= '0;
			rx_q        <= '0;
			bit_count_q <= '0;
			presc_q     <= '0;
			half_q      <= 1'b0;
			active_q    <= 1'b0;
			done_q      <= 1'b0;
			coll_q      <= 1'b0;
			armed_q     <= 1'b0;
			held_q      <= 1'b0;
		end else if (step) begin
			shift_q     <= sr_d;
			rx_q        <= rx_d;
			bit_count_q <= bc_d;
			presc_q     <= pc_d;
			half_q      <= hp_d;
			active_q    <= act_d;
			done_q      <= done_d;
			coll_q      <= coll_d;
			armed_q     <= armed_d;
			held_q      <= held_d;
		end else if (stop) begin
			bit_count_q <= '0;
			presc_q     <= '0;
			half_q      <= 1'b0;
			active_q    <= 1'b0;
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (bit_count_q == '0) && (presc_q == '0) && !half_q)
		else $error("idle port holds exchange counters");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_count_q < spi_mp_pkg::COUNT_W'(spi_mp_pkg::BITS_PER_XFER))
		else $error("bit count out of range");

	a_done_ends_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(active_q))
		else $error("done set outside the end of an exchange");

	a_presc_range: assert property (@(posedge clk) disable iff (!arst_n)
		presc_q < 7'd64)
		else $error("prescaler past the longest half period");

	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_regs.port_enable |=> !active_q || $past(step))
		else $error("exchange runs with the port disabled");

endmodule

>>> src/spi_master_port_unit.sv
// ----------------------------------------------------------------------------
// spi_master_port_unit
// 8-bit SPI master port, one system tick per transaction.
// ----------------------------------------------------------------------------
// Each item transaction is one system clock tick of the port. An item is
// taken into an input register, and from there the tick is applied to the
// exchange state in a single combinational pass whose result lands in the
// output register, and a new item is accepted every cycle as long as results
// are taken. The serial clock half period is 1, 4, 16 or 32 ticks with double
// speed, 2, 8, 32 or 64 without, counted on ticks.
module spi_master_port_unit (
	input  logic             clk,
	input  logic             arst_n,
	spi_mp_item_if.sink      item,
	spi_mp_result_if.source  result,
	spi_mp_cfg_if.sink       cfg
);

	spi_mp_pkg::cfg_t    cfg_regs;
	spi_mp_pkg::item_t   item_s1;
	spi_mp_pkg::result_t res_d, result_q;
	logic                stop, valid_s1, out_valid_q, adv;

	spi_mp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs),
		.stop     (stop)
	);

	spi_mp_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_regs),
		.stop     (stop),
		.step     (adv),
		.item     (item_s1),
		.res      (res_d)
	);

	assign adv        = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.mode       <= item.mode;
			item_s1.write_data <= item.write_data;
			item_s1.miso_in    <= item.miso_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q <= res_d;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.read_data = result_q.read_data;
	assign result.sclk_out  = result_q.sclk_out;
	assign result.mosi_out  = result_q.mosi_out;
	assign result.busy_res  = result_q.busy_res;
	assign result.irq       = result_q.irq;

endmodule

>>> test/spi_port_sb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi_port_sb_pkg
// Scoreboard of the SPI master port testbench. It keeps its own copy of the
// port registers and exchange state, predicts the bus and pin sample that
// every item transaction produces, and compares each result against it.
// ----------------------------------------------------------------------------
package spi_port_sb_pkg;

	import spi_mp_pkg::*;

	class spi_port_scoreboard;
		cfg_t                regs;
		logic [DATA_W-1:0]   shifter;
		logic [DATA_W-1:0]   rx_buf;
		logic [COUNT_W-1:0]  edges_done;
		logic [PRESC_W-1:0]  presc;
		logic                half_ph;
		logic                busy;
		logic                done_f;
		logic                coll_f;
		logic                armed;
		logic                held_bit;
		result_t             predicted_samples[$];
		int unsigned         errors;
		int unsigned         checked;
		int unsigned         exchanges;
		int unsigned         collisions;

		function new();
			regs = '0;
			shifter = '0;
			rx_buf = '0;
			edges_done = '0;
			presc = '0;
			half_ph = 1'b0;
			busy = 1'b0;
			done_f = 1'b0;
			coll_f = 1'b0;
			armed = 1'b0;
			held_bit = 1'b0;
			errors = 0;
			checked = 0;
			exchanges = 0;
			collisions = 0;
		endfunction

		function int unsigned pending();
			return predicted_samples.size();
		endfunction

		function logic serial_bit();
			return regs.lsb_first ? shifter[0] : shifter[DATA_W-1];
		endfunction

		function void end_exchange();
			busy = 1'b0;
			edges_done = '0;
			presc = '0;
			half_ph = 1'b0;
		endfunction

		// advance the serial clock by one system tick
		function void clock_tick(logic miso);
			logic [PRESC_W-1:0] half;
			logic               b;
			if (!busy)
				return;
			case (regs.rate_select)
				2'd0: half = 7'd2;
				2'd1: half = 7'd8;
				2'd2: half = 7'd32;
				default: half = 7'd64;
			endcase
			if (regs.double_speed)
				half = half >> 1;
			presc = presc + 1'b1;
			if (presc < half)
				return;
			presc = '0;
			if (!half_ph) begin
				half_ph = 1'b1;
				held_bit = regs.clock_phase ? serial_bit() : miso;
			end else begin
				half_ph = 1'b0;
				b = regs.clock_phase ? miso : held_bit;
				shifter = regs.lsb_first ? {b, shifter[DATA_W-1:1]} : {shifter[DATA_W-2:0], b};
				edges_done = edges_done + 1'b1;
				if (edges_done >= BITS_PER_XFER) begin
					end_exchange();
					rx_buf = shifter;
					done_f = 1'b1;
					exchanges++;
				end
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				REG_PORT_ENABLE: begin
					regs.port_enable = val[0];
					if (!val[0])
						end_exchange();
				end
				REG_LSB_FIRST:   regs.lsb_first = val[0];
				REG_CLOCK_POL:   regs.clock_polarity = val[0];
				REG_CLOCK_PHASE: regs.clock_phase = val[0];
				REG_RATE_SELECT: regs.rate_select = val;
				REG_DOUBLE_SPD:  regs.double_speed = val[0];
				REG_IRQ_ENABLE:  regs.interrupt_enable = val[0];
				default: ;
			endcase
		endfunction

		function void note_transaction(item_t it);
			result_t           want;
			logic [DATA_W-1:0] rd;
			rd = '0;
			if (!regs.port_enable)
				end_exchange();
			clock_tick(it.miso_in);
			case (it.mode)
				MODE_WRITE: begin
					if (regs.port_enable) begin
						if (busy) begin
							coll_f = 1'b1;
							collisions++;
						end else begin
							shifter = it.write_data;
							busy = 1'b1;
							edges_done = '0;
							presc = '0;
							half_ph = 1'b0;
						end
					end
				end
				MODE_STATUS: begin
					rd[STATUS_DONE_BIT] = done_f;
					rd[STATUS_COLL_BIT] = coll_f;
					rd[STATUS_DSPD_BIT] = regs.double_speed;
					if (done_f || coll_f)
						armed = 1'b1;
				end
				MODE_READ: begin
					rd = rx_buf;
					if (armed) begin
						done_f = 1'b0;
						coll_f = 1'b0;
						armed = 1'b0;
					end
				end
				default: ;
			endcase
			want.read_data = rd;
			want.sclk_out = regs.clock_polarity ^ half_ph;
			want.mosi_out = regs.clock_phase ? held_bit : serial_bit();
			want.busy_res = busy;
			want.irq = done_f & regs.interrupt_enable;
			predicted_samples.push_back(want);
		endfunction

		function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] seen);
			if (seen !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
				errors++;
			end
		endfunction

		function void check_sample(result_t got);
			result_t want;
			if (predicted_samples.size() == 0) begin
				$error("unexpected result transaction: read_data 0x%0h", got.read_data);
				errors++;
				return;
			end
			want = predicted_samples.pop_front();
			checked++;
			compare_field("read_data", want.read_data, got.read_data);
			compare_field("sclk_out", want.sclk_out, got.sclk_out);
			compare_field("mosi_out", want.mosi_out, got.mosi_out);
			compare_field("busy_res", want.busy_res, got.busy_res);
			compare_field("irq", want.irq, got.irq);
		endfunction
	endclass

endpackage

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the SPI master port. Drives tick, write, status and read
// transactions under many register settings and random handshake stalls, and
// checks every result sample against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;

	import spi_mp_pkg::*;
	import spi_port_sb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_IDX_NONE = 3'd7;
	localparam int unsigned NUM_PHASES    = 13;
	localparam int unsigned SLOW_PHASE    = 5;
	localparam int unsigned PARTIAL_PHASE = 9;

	logic               clk;
	logic               arst_n;
	int unsigned        tx_idle_pct;
	int unsigned        rx_idle_pct;
	int unsigned        item_count;
	spi_port_scoreboard sb;

	spi_mp_item_if   item_ch();
	spi_mp_result_if result_ch();
	spi_mp_cfg_if    cfg_ch();

	spi_master_port_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		result_ch.ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_sample('{read_data: result_ch.read_data, sclk_out: result_ch.sclk_out,
				mosi_out: result_ch.mosi_out, busy_res: result_ch.busy_res, irq: result_ch.irq});
	end

	task automatic send_item(mode_t m, logic [DATA_W-1:0] d, logic b);
		item_t it;
		while ($urandom_range(99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		it = '{mode: m, write_data: d, miso_in: b};
		item_ch.valid <= 1'b1;
		item_ch.mode <= m;
		item_ch.write_data <= d;
		item_ch.miso_in <= b;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_transaction(it);
		item_count++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wr_data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, val);
	endtask

	// spare upper data bit goes out random on single-bit registers
	task automatic apply_config(cfg_t c, bit poke_unused);
		write_reg(REG_PORT_ENABLE, {1'($urandom_range(1)), c.port_enable});
		write_reg(REG_LSB_FIRST, {1'($urandom_range(1)), c.lsb_first});
		write_reg(REG_CLOCK_POL, {1'($urandom_range(1)), c.clock_polarity});
		write_reg(REG_CLOCK_PHASE, {1'($urandom_range(1)), c.clock_phase});
		write_reg(REG_RATE_SELECT, c.rate_select);
		write_reg(REG_DOUBLE_SPD, {1'($urandom_range(1)), c.double_speed});
		write_reg(REG_IRQ_ENABLE, {1'($urandom_range(1)), c.interrupt_enable});
		if (poke_unused)
			write_reg(REG_IDX_NONE, 2'b11);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random(int unsigned n, int unsigned tick_pct);
		int unsigned r;
		int unsigned rest;
		bit          read_next;
		read_next = 1'b0;
		rest = 100 - tick_pct;
		repeat (n) begin
			r = $urandom_range(99);
			if (read_next) begin
				read_next = 1'b0;
				send_item(MODE_READ, 8'($urandom), 1'($urandom));
			end else if (r < tick_pct) begin
				send_item(MODE_TICK, 8'($urandom), 1'($urandom));
			end else if (r < tick_pct + rest / 2) begin
				send_item(MODE_WRITE, 8'($urandom), 1'($urandom));
			end else if (r < tick_pct + (3 * rest) / 4) begin
				send_item(MODE_STATUS, 8'($urandom), 1'($urandom));
				read_next = 1'($urandom_range(1));
			end else begin
				send_item(MODE_READ, 8'($urandom), 1'($urandom));
			end
		end
	endtask

	initial begin
		cfg_t        c;
		int unsigned n;
		int unsigned tick_pct;
		sb = new();
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_TICK;
		item_ch.write_data = '0;
		item_ch.miso_in = 1'b0;
		result_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = '0;
		cfg_ch.wr_data = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		item_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// port still disabled out of reset: write is ignored
		send_item(MODE_WRITE, 8'hA5, 1'b1);
		send_item(MODE_STATUS, 8'h00, 1'b0);
		send_item(MODE_READ, 8'h00, 1'b0);
		wait_idle();

		c = '{port_enable: 1'b1, lsb_first: 1'b0, clock_polarity: 1'b0, clock_phase: 1'b0,
			rate_select: 2'd0, double_speed: 1'b1, interrupt_enable: 1'b1};
		apply_config(c, 1'b1);
		send_item(MODE_WRITE, 8'hFF, 1'b0);
		send_item(MODE_WRITE, 8'h00, 1'b1);
		for (int i = 0; i < 16; i++)
			send_item(MODE_TICK, 8'h00, 1'(i));
		send_item(MODE_STATUS, 8'h00, 1'b0);
		send_item(MODE_READ, 8'h00, 1'b0);
		send_item(MODE_STATUS, 8'h00, 1'b0);
		send_item(MODE_READ, 8'h00, 1'b0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			case (p % 3)
				0: begin
					tx_idle_pct = 22;
					rx_idle_pct = 65;
				end
				1: begin
					tx_idle_pct = 65;
					rx_idle_pct = 22;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			c = cfg_t'(8'($urandom));
			c.port_enable = (p == 3 || p == 10) ? 1'b0 : 1'b1;
			c.rate_select = ($urandom_range(99) < 70) ? 2'($urandom_range(1)) :
				2'($urandom_range(3));
			n = 55;
			tick_pct = 70;
			if (p == 0) begin
				c.rate_select = 2'd0;
				c.double_speed = 1'b1;
			end else if (p == SLOW_PHASE) begin
				c.rate_select = 2'd3;
				c.double_speed = 1'b1;
				n = 620;
				tick_pct = 95;
			end else if (p == PARTIAL_PHASE) begin
				c.rate_select = 2'd3;
				c.double_speed = 1'b0;
				n = 60;
			end
			apply_config(c, 1'b0);
			if (p == SLOW_PHASE)
				send_item(MODE_WRITE, 8'($urandom), 1'($urandom));
			run_random(n, tick_pct);
		end
		wait_idle();
		repeat (10) @(posedge clk);

		$display("Summary: %0d item transactions in %0d register settings, %0d samples checked",
			item_count, NUM_PHASES + 2, sb.checked);
		$display("Summary: %0d exchanges completed, %0d colliding writes, %0d mismatches",
			sb.exchanges, sb.collisions, sb.errors);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
